// File: rtl/core/bit_stack_with_range_fill_unit_macros.svh
// Assertion macros shared by the bit stack RTL.
`ifndef BIT_STACK_WITH_RANGE_FILL_UNIT_MACROS_SVH
`define BIT_STACK_WITH_RANGE_FILL_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BSRF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsrf check failed");

// Next-cycle implication, disabled during reset.
`define BSRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsrf check failed");

`endif

// File: rtl/core/bsrf_pkg.sv
// Package: types, codes and sizing helpers of the bit stack unit.
package bsrf_pkg;

   localparam int BSRF_CAPACITY_BITS = 4096;
   localparam int BSRF_WORD_BITS     = 64;

   localparam int OP_W       = 3;
   localparam int POS_W      = 12;
   localparam int LEN_PORT_W = 13;
   localparam int STAT_W     = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_TOP    = 3'd2,
      OP_GET    = 3'd3,
      OP_SET    = 3'd4,
      OP_FILL   = 3'd5,
      OP_RESIZE = 3'd6,
      OP_CLEAR  = 3'd7
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_SPLIT = 2'd1,
      S_ISSUE = 2'd2,
      S_WALK  = 2'd3
   } state_type;

   // Address bits for a store of the given depth (at least one).
   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// File: rtl/core/bsrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsrf_ram
   import bsrf_pkg::*;
#(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [addr_bits(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]            wr_data,
   input  logic [addr_bits(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bsrf_split.sv
// Two-stage split of a bit index into word address and bit offset.
module bsrf_split
   import bsrf_pkg::*;
#(
   parameter int IDX_W     = 12,
   parameter int WORD_BITS = 64,
   parameter int WORDS     = 64
) (
   input  logic                        clock,
   input  logic [IDX_W-1:0]            index,
   output logic [addr_bits(WORDS)-1:0] word_out,
   output logic [$clog2(WORD_BITS)-1:0] bit_out
);

   localparam int AW = addr_bits(WORDS);
   localparam int BW = $clog2(WORD_BITS);
   localparam int SH = IDX_W + BW;
   localparam int MW = IDX_W + 2;
   localparam int PW = IDX_W + MW;
   // ceil(2^SH / WORD_BITS): exact quotient for every index below 2^IDX_W
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
   localparam logic [IDX_W-1:0] WB = IDX_W'(WORD_BITS);

   logic [PW-1:0]    prod;
   logic [AW-1:0]    q_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] base;
   logic [IDX_W-1:0] rem;
   logic [AW-1:0]    word_ff;
   logic [BW-1:0]    bit_ff;

   assign prod = PW'(index) * PW'(RECIP);
   assign base = IDX_W'(q_ff) * WB;
   assign rem  = idx_ff - base;

   always_ff @(posedge clock) begin
      q_ff    <= AW'(prod >> SH);
      idx_ff  <= index;
      word_ff <= q_ff;
      bit_ff  <= rem[BW-1:0];
   end

   assign word_out = word_ff;
   assign bit_out  = bit_ff;

endmodule

// File: rtl/core/bit_stack_with_range_fill_unit.sv
// Top level: bounded bit stack with indexed access and range fill.
//
//  channel   direction  handshake                 payload
//  request   in         start & !busy             req_op, req_bit_value, req_position,
//                                                 req_position_end, req_new_length,
//                                                 req_clear_new
//  response  out        rsp_strobe (one cycle)    rsp_bit_out, rsp_length_now, rsp_status
//
//  Pop, clear, every resize that does not grow with clearing and every failing item answer
//  in the cycle after start without raising busy.
//  Top, get, push and set hold busy through the index split (two stages), the word read
//  of the store RAM and the read-modify-write or bit pick.
//  Fill and clearing resize hold busy to split, read, then walk the range one RAM word per cycle.
//  Reset is synchronous, active high; it clears the length and the control state, and
//  the store is undefined until written. The response cannot be stalled.
`include "bit_stack_with_range_fill_unit_macros.svh"

module bit_stack_with_range_fill_unit
   import bsrf_pkg::*;
#(
   parameter int CAPACITY_BITS = BSRF_CAPACITY_BITS,
   parameter int WORD_BITS     = BSRF_WORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic                  req_bit_value,
   input  logic [POS_W-1:0]      req_position,
   input  logic [POS_W-1:0]      req_position_end,
   input  logic [LEN_PORT_W-1:0] req_new_length,
   input  logic                  req_clear_new,
   output logic                  rsp_strobe,
   output logic                  rsp_bit_out,
   output logic [LEN_PORT_W-1:0] rsp_length_now,
   output logic [STAT_W-1:0]     rsp_status
);

   localparam int WORDS = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int IDX_W = $clog2(CAPACITY_BITS);
   localparam int LEN_W = $clog2(CAPACITY_BITS + 1);
   localparam int AW    = addr_bits(WORDS);
   localparam int BW    = $clog2(WORD_BITS);
   localparam int CW    = (LEN_W > LEN_PORT_W) ? LEN_W : LEN_PORT_W;

   // control
   state_type        state_ff, state_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   // item held while the store is walked
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic             fill_v_ff, fill_v_in;
   logic             is_read_ff, is_read_in;
   logic [AW-1:0]    word_ff, word_in;

   // response payload
   logic                  rsp_bit_ff, rsp_bit_in;
   logic [LEN_PORT_W-1:0] rsp_len_ff, rsp_len_in;
   status_type            rsp_status_ff, rsp_status_in;

   // decode of the offered item
   status_type       dec_status;
   logic [LEN_W-1:0] dec_len;
   logic [IDX_W-1:0] dec_lo, dec_hi;
   logic             dec_mem, dec_read;

   logic [CW-1:0] len_x, pos_x, end_x, nl_x, cap_x;

   // store access
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data, ram_wr_data, mask;

   logic [AW-1:0] word_lo, word_hi;
   logic [BW-1:0] bit_lo, bit_hi;

   assign len_x = CW'(length_ff);
   assign pos_x = CW'(req_position);
   assign end_x = CW'(req_position_end);
   assign nl_x  = CW'(req_new_length);
   assign cap_x = CW'(CAPACITY_BITS);

   // Decode: check bounds, pick the index range and the length after the item.
   always_comb begin
      dec_status = STAT_OK;
      dec_len    = length_ff;
      dec_lo     = IDX_W'(length_ff);
      dec_hi     = IDX_W'(length_ff);
      dec_mem    = 1'b0;
      dec_read   = 1'b0;
      unique case (op_type'(req_op))
         OP_PUSH: begin
            if (len_x >= cap_x) begin
               dec_status = STAT_FULL;
            end else begin
               dec_mem = 1'b1;
               dec_len = length_ff + LEN_W'(1);
            end
         end
         OP_POP: begin
            if (len_x == '0) begin
               dec_status = STAT_EMPTY;
            end else begin
               dec_len = length_ff - LEN_W'(1);
            end
         end
         OP_TOP: begin
            if (len_x == '0) begin
               dec_status = STAT_EMPTY;
            end else begin
               dec_mem  = 1'b1;
               dec_read = 1'b1;
               dec_lo   = IDX_W'(length_ff - LEN_W'(1));
               dec_hi   = IDX_W'(length_ff - LEN_W'(1));
            end
         end
         OP_GET, OP_SET: begin
            if (pos_x >= len_x) begin
               dec_status = STAT_RANGE;
            end else begin
               dec_mem  = 1'b1;
               dec_read = (op_type'(req_op) == OP_GET);
               dec_lo   = IDX_W'(pos_x);
               dec_hi   = IDX_W'(pos_x);
            end
         end
         OP_FILL: begin
            if (pos_x >= len_x || end_x >= len_x) begin
               dec_status = STAT_RANGE;
            end else begin
               dec_mem = 1'b1;
               // swap ends given in reverse order
               if (pos_x <= end_x) begin
                  dec_lo = IDX_W'(pos_x);
                  dec_hi = IDX_W'(end_x);
               end else begin
                  dec_lo = IDX_W'(end_x);
                  dec_hi = IDX_W'(pos_x);
               end
            end
         end
         OP_RESIZE: begin
            if (nl_x > cap_x) begin
               dec_status = STAT_FULL;
            end else begin
               dec_len = LEN_W'(nl_x);
               // growing with clear: zero the added bits
               if (nl_x > len_x && req_clear_new) begin
                  dec_mem = 1'b1;
                  dec_hi  = IDX_W'(nl_x - CW'(1));
               end
            end
         end
         OP_CLEAR: begin
            dec_len = '0;
         end
      endcase
   end

   bsrf_split #(
      .IDX_W     (IDX_W),
      .WORD_BITS (WORD_BITS),
      .WORDS     (WORDS)
   ) u_split_lo (
      .clock    (clock),
      .index    (lo_in),
      .word_out (word_lo),
      .bit_out  (bit_lo)
   );

   bsrf_split #(
      .IDX_W     (IDX_W),
      .WORD_BITS (WORD_BITS),
      .WORDS     (WORDS)
   ) u_split_hi (
      .clock    (clock),
      .index    (hi_in),
      .word_out (word_hi),
      .bit_out  (bit_hi)
   );

   // Bits of the current word that lie inside the range.
   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         mask[j] = (word_ff != word_lo || BW'(j) >= bit_lo) &&
                   (word_ff != word_hi || BW'(j) <= bit_hi);
      end
   end

   assign ram_wr_data = fill_v_ff ? (ram_rd_data | mask) : (ram_rd_data & ~mask);

   bsrf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (word_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer: answer store-free items at once; else split the indexes, read the first word, then
   // pick the read bit, or modify and write back one word per cycle while reading the next one.
   always_comb begin
      state_in      = state_ff;
      length_in     = length_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      fill_v_in     = fill_v_ff;
      is_read_in    = is_read_ff;
      word_in       = word_ff;
      rsp_strobe_in = 1'b0;
      rsp_bit_in    = rsp_bit_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_rd_addr   = word_lo;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               length_in  = dec_len;
               lo_in      = dec_lo;
               hi_in      = dec_hi;
               fill_v_in  = req_bit_value && (op_type'(req_op) != OP_RESIZE);
               is_read_in = dec_read;
               if (dec_mem) begin
                  state_in = S_SPLIT;
               end else begin
                  // answer at once: nothing to touch in the store
                  rsp_strobe_in = 1'b1;
                  rsp_bit_in    = 1'b0;
                  rsp_len_in    = LEN_PORT_W'(dec_len);
                  rsp_status_in = dec_status;
               end
            end
         end
         S_SPLIT: begin
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            ram_rd_addr = word_lo;
            word_in     = word_lo;
            state_in    = S_WALK;
         end
         S_WALK: begin
            if (is_read_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_bit_in    = ram_rd_data[bit_lo];
               rsp_len_in    = LEN_PORT_W'(length_ff);
               rsp_status_in = STAT_OK;
               state_in      = S_IDLE;
            end else begin
               ram_wr_en = 1'b1;
               if (word_ff == word_hi) begin
                  rsp_strobe_in = 1'b1;
                  rsp_bit_in    = 1'b0;
                  rsp_len_in    = LEN_PORT_W'(length_ff);
                  rsp_status_in = STAT_OK;
                  state_in      = S_IDLE;
               end else begin
                  // advance to the next word, read it while this one is written
                  word_in     = word_ff + AW'(1);
                  ram_rd_addr = word_ff + AW'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         length_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         length_ff     <= length_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      fill_v_ff     <= fill_v_in;
      is_read_ff    <= is_read_in;
      word_ff       <= word_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_bit_out    = rsp_bit_ff;
   assign rsp_length_now = rsp_len_ff;
   assign rsp_status     = rsp_status_ff;

   `BSRF_ASSERT_IMPL(a_strobe_idle, clock, reset, rsp_strobe_ff, state_ff == S_IDLE)
   `BSRF_ASSERT_NEXT(a_quick_answer, clock, reset, state_ff == S_IDLE && start && !dec_mem, rsp_strobe_ff)
   `BSRF_ASSERT_IMPL(a_walk_bound, clock, reset, state_ff == S_WALK, word_ff <= word_hi)
   `BSRF_ASSERT_IMPL(a_len_bound, clock, reset, 1'b1, len_x <= cap_x)

endmodule

// File: sim/bsrf_tb_pkg.sv
`timescale 1ns / 1ps
// Reply tracker: mirrors the bit stack, predicts each reply and checks the block's replies.
package bsrf_tb_pkg;
   import bsrf_pkg::*;

   localparam int STACK_BITS = BSRF_CAPACITY_BITS;

   typedef struct {
      bit                    bit_out;
      bit [LEN_PORT_W-1:0]   length_now;
      status_type            status;
      longint unsigned       accepted_at;
   } reply_type;

   class bit_stack_tracker;
      bit              mirror_bits [STACK_BITS];
      bit              written     [STACK_BITS];
      int unsigned     depth_now;
      int unsigned     errors;
      reply_type       pending_replies [$];

      function void put_bit(int unsigned idx, bit v);
         mirror_bits[idx] = v;
         written[idx]     = 1'b1;
      endfunction

      // Apply one accepted item to the mirror and queue the reply it must produce.
      function void log_request(op_type op, bit v, bit [POS_W-1:0] pos,
                                bit [POS_W-1:0] pos_end, bit [LEN_PORT_W-1:0] new_len,
                                bit clr);
         reply_type   reply;
         int unsigned lo;
         int unsigned hi;
         int unsigned p;
         reply.bit_out     = 1'b0;
         reply.status      = STAT_OK;
         reply.accepted_at = $time;
         case (op)
            OP_PUSH: begin
               if (depth_now >= STACK_BITS) begin
                  reply.status = STAT_FULL;
               end else begin
                  put_bit(depth_now, v);
                  depth_now++;
               end
            end
            OP_POP: begin
               if (depth_now == 0) reply.status = STAT_EMPTY;
               else depth_now--;
            end
            OP_TOP: begin
               if (depth_now == 0) reply.status = STAT_EMPTY;
               else reply.bit_out = mirror_bits[depth_now - 1];
            end
            OP_GET: begin
               if (pos >= depth_now) reply.status = STAT_RANGE;
               else reply.bit_out = mirror_bits[pos];
            end
            OP_SET: begin
               if (pos >= depth_now) reply.status = STAT_RANGE;
               else put_bit(pos, v);
            end
            OP_FILL: begin
               if (pos >= depth_now || pos_end >= depth_now) begin
                  reply.status = STAT_RANGE;
               end else begin
                  lo = (pos <= pos_end) ? pos : pos_end;
                  hi = (pos <= pos_end) ? pos_end : pos;
                  for (p = lo; p <= hi; p++) put_bit(p, v);
               end
            end
            OP_RESIZE: begin
               if (new_len > STACK_BITS) begin
                  reply.status = STAT_FULL;
               end else begin
                  if (new_len > depth_now && clr) begin
                     for (p = depth_now; p < new_len; p++) put_bit(p, 1'b0);
                  end
                  depth_now = new_len;
               end
            end
            OP_CLEAR: depth_now = 0;
         endcase
         reply.length_now = depth_now[LEN_PORT_W-1:0];
         pending_replies.push_back(reply);
      endfunction

      // Compare one reply against the oldest queued prediction.
      function void check_reply(logic bit_out, logic [LEN_PORT_W-1:0] len,
                                logic [STAT_W-1:0] st);
         reply_type want;
         if (pending_replies.size() == 0 || pending_replies[0].accepted_at >= $time) begin
            errors++;
            $display("%0t: reply with no item waiting (bit %b length %0d status %0d)",
                     $time, bit_out, len, st);
            return;
         end
         want = pending_replies.pop_front();
         if (bit_out !== want.bit_out) begin
            errors++;
            $display("%0t: bit_out mismatch, expected %b, actual %b",
                     $time, want.bit_out, bit_out);
         end
         if (len !== want.length_now) begin
            errors++;
            $display("%0t: length_now mismatch, expected %0d, actual %0d",
                     $time, want.length_now, len);
         end
         if (st !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, st);
         end
      endfunction
   endclass

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives directed and random items into the bit stack unit and checks replies.
module tb_top;
   import bsrf_pkg::*;
   import bsrf_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1875;
   // Longest busy stretch is a fill or clearing resize over all 64 words, plus margin.
   localparam int DRAIN_CYCLES = 80;
   localparam int FULL_BITS    = BSRF_CAPACITY_BITS;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [OP_W-1:0]       req_op;
   logic                  req_bit_value;
   logic [POS_W-1:0]      req_position;
   logic [POS_W-1:0]      req_position_end;
   logic [LEN_PORT_W-1:0] req_new_length;
   logic                  req_clear_new;
   logic                  rsp_strobe;
   logic                  rsp_bit_out;
   logic [LEN_PORT_W-1:0] rsp_length_now;
   logic [STAT_W-1:0]     rsp_status;

   bit_stack_tracker board = new();
   // While set, items go back to back with no idle cycles.
   bit               quiet_stretch;

   always #5 clock = ~clock;

   bit_stack_with_range_fill_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_bit_value    (req_bit_value),
      .req_position     (req_position),
      .req_position_end (req_position_end),
      .req_new_length   (req_new_length),
      .req_clear_new    (req_clear_new),
      .rsp_strobe       (rsp_strobe),
      .rsp_bit_out      (rsp_bit_out),
      .rsp_length_now   (rsp_length_now),
      .rsp_status       (rsp_status)
   );

   // Watchdog: stop a hung run, well beyond the slowest correct one.
   initial begin
      #10_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   // Take every strobed reply; the block cannot be stalled, so check on the spot.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         board.check_reply(rsp_bit_out, rsp_length_now, rsp_status);
      end
   end

   // Offer one item after a random idle gap, hold it until accepted, then log it.
   task automatic send_request(input op_type op, input bit v, input bit [POS_W-1:0] pos,
                               input bit [POS_W-1:0] pos_end,
                               input bit [LEN_PORT_W-1:0] new_len, input bit clr);
      int unsigned gap;
      int unsigned roll;
      if ($urandom_range(0, 99) == 0) quiet_stretch = !quiet_stretch;
      roll = $urandom_range(0, 99);
      if (quiet_stretch || roll < 45) gap = 0;
      else if (roll < 80) gap = $urandom_range(1, 3);
      else if (roll < 96) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 40);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_op           <= op;
      req_bit_value    <= v;
      req_position     <= pos;
      req_position_end <= pos_end;
      req_new_length   <= new_len;
      req_clear_new    <= clr;
      do @(posedge clock); while (busy !== 1'b0);
      board.log_request(op, v, pos, pos_end, new_len, clr);
   endtask

   // Any index below the current length (length must be nonzero).
   function automatic bit [POS_W-1:0] index_within();
      return POS_W'($urandom_range(0, board.depth_now - 1));
   endfunction

   // An index at or beyond the length; when the vector is full, fall back to a valid one.
   function automatic bit [POS_W-1:0] index_beyond();
      if (board.depth_now >= FULL_BITS) return POS_W'($urandom_range(0, FULL_BITS - 1));
      if ($urandom_range(0, 1)) return POS_W'(board.depth_now);
      return POS_W'($urandom_range(board.depth_now, FULL_BITS - 1));
   endfunction

   // Pick one random item, mostly legal for the current length, and send it.
   task automatic send_random();
      op_type                op;
      bit                    v;
      bit [POS_W-1:0]        pos;
      bit [POS_W-1:0]        pos_end;
      bit [POS_W-1:0]        candidate;
      bit [LEN_PORT_W-1:0]   new_len;
      bit                    clr;
      int                    depth;
      int                    near;
      int unsigned           pick;
      int unsigned           tries;
      depth   = board.depth_now;
      // Randomize every field; unused ones must be ignored by the block.
      v       = 1'($urandom);
      pos     = POS_W'($urandom);
      pos_end = POS_W'($urandom);
      new_len = LEN_PORT_W'($urandom);
      clr     = 1'($urandom);
      pick    = $urandom_range(0, 99);
      if (pick < 20) begin
         op = OP_PUSH;
      end else if (pick < 30) begin
         op = OP_POP;
      end else if (pick < 36) begin
         // Never read a top bit that was not written since reset.
         op = (depth != 0 && !board.written[depth - 1]) ? OP_POP : OP_TOP;
      end else if (pick < 50) begin
         op  = OP_GET;
         pos = index_beyond();
         if (depth != 0 && $urandom_range(0, 99) < 85) begin
            for (tries = 0; tries < 8; tries++) begin
               candidate = index_within();
               if (board.written[candidate]) begin
                  pos = candidate;
                  break;
               end
            end
         end
         // Turn a read of a never-written bit into a write of it.
         if (pos < depth && !board.written[pos]) op = OP_SET;
      end else if (pick < 62) begin
         op  = OP_SET;
         pos = (depth != 0 && $urandom_range(0, 99) < 85) ? index_within() : index_beyond();
      end else if (pick < 75) begin
         op = OP_FILL;
         if (depth != 0 && $urandom_range(0, 99) < 88) begin
            pos = index_within();
            if ($urandom_range(0, 9) < 7) begin
               // Short span around the start, either direction, across word edges.
               near = int'(pos) + int'($urandom_range(0, 140)) - 70;
               if (near < 0) near = 0;
               if (near >= depth) near = depth - 1;
               pos_end = POS_W'(near);
            end else begin
               pos_end = index_within();
            end
         end else begin
            pos = index_beyond();
            if ($urandom_range(0, 1)) {pos, pos_end} = {pos_end, pos};
         end
      end else if (pick < 93) begin
         op   = OP_RESIZE;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            near = depth + int'($urandom_range(0, 130)) - 60;
            if (near < 0) near = 0;
            if (near > FULL_BITS) near = FULL_BITS;
            new_len = LEN_PORT_W'(near);
         end else if (pick < 75) begin
            new_len = LEN_PORT_W'($urandom_range(0, FULL_BITS));
         end else if (pick < 85) begin
            new_len = LEN_PORT_W'(FULL_BITS);
         end else if (pick < 95) begin
            new_len = LEN_PORT_W'($urandom_range(FULL_BITS + 1, (1 << LEN_PORT_W) - 1));
         end else begin
            new_len = LEN_PORT_W'(depth);
         end
      end else begin
         op = OP_CLEAR;
      end
      send_request(op, v, pos, pos_end, new_len, clr);
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_op           <= OP_PUSH;
      req_bit_value    <= 1'b0;
      req_position     <= '0;
      req_position_end <= '0;
      req_new_length   <= '0;
      req_clear_new    <= 1'b0;
      quiet_stretch     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty vector: every read, write and fill must fail.
      send_request(OP_POP,    1'b0, 12'd0,    12'd0,    13'd0,    1'b0);
      send_request(OP_TOP,    1'b1, 12'd0,    12'd0,    13'd0,    1'b0);
      send_request(OP_GET,    1'b0, 12'd0,    12'd0,    13'd0,    1'b0);
      send_request(OP_SET,    1'b1, 12'd0,    12'd0,    13'd0,    1'b0);
      send_request(OP_FILL,   1'b1, 12'd0,    12'd0,    13'd0,    1'b0);
      // Two bits, read back, then a reversed fill.
      send_request(OP_PUSH,   1'b1, 12'd0,    12'd0,    13'd0,    1'b0);
      send_request(OP_PUSH,   1'b0, 12'd0,    12'd0,    13'd0,    1'b0);
      send_request(OP_TOP,    1'b0, 12'd0,    12'd0,    13'd0,    1'b0);
      send_request(OP_GET,    1'b0, 12'd0,    12'd0,    13'd0,    1'b0);
      send_request(OP_SET,    1'b1, 12'd1,    12'd0,    13'd0,    1'b0);
      send_request(OP_FILL,   1'b0, 12'd1,    12'd0,    13'd0,    1'b0);
      // Index equal to the length, and a fill whose far end is out of range.
      send_request(OP_GET,    1'b0, 12'd2,    12'd0,    13'd0,    1'b0);
      send_request(OP_FILL,   1'b1, 12'd0,    12'd4095, 13'd0,    1'b0);
      // Resize past capacity, then grow to capacity with clearing.
      send_request(OP_RESIZE, 1'b0, 12'd0,    12'd0,    13'd4097, 1'b1);
      send_request(OP_RESIZE, 1'b0, 12'd0,    12'd0,    13'd8191, 1'b0);
      send_request(OP_RESIZE, 1'b0, 12'd0,    12'd0,    13'd4096, 1'b1);
      send_request(OP_PUSH,   1'b1, 12'd0,    12'd0,    13'd0,    1'b0);
      // Full-range fill and the last index.
      send_request(OP_FILL,   1'b1, 12'd0,    12'd4095, 13'd0,    1'b0);
      send_request(OP_GET,    1'b0, 12'd4095, 12'd0,    13'd0,    1'b0);
      send_request(OP_SET,    1'b0, 12'd4095, 12'd0,    13'd0,    1'b0);
      send_request(OP_TOP,    1'b1, 12'd0,    12'd0,    13'd0,    1'b0);
      // Same-length resize, shrink, grow without clearing, clear, resize to zero.
      send_request(OP_RESIZE, 1'b1, 12'd0,    12'd0,    13'd4096, 1'b0);
      send_request(OP_RESIZE, 1'b0, 12'd0,    12'd0,    13'd100,  1'b1);
      send_request(OP_RESIZE, 1'b0, 12'd0,    12'd0,    13'd3000, 1'b0);
      send_request(OP_CLEAR,  1'b1, 12'd4095, 12'd4095, 13'd8191, 1'b1);
      send_request(OP_RESIZE, 1'b0, 12'd0,    12'd0,    13'd0,    1'b1);

      repeat (RANDOM_ITEMS) send_random();
      start <= 1'b0;

      // Drain: wait for every reply, then let any late strobe show up.
      while (board.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_replies.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// File: bit_stack_with_range_fill_unit.f
+incdir+rtl/core
rtl/core/bsrf_pkg.sv
rtl/core/bsrf_ram.sv
rtl/core/bsrf_split.sv
rtl/core/bit_stack_with_range_fill_unit.sv
sim/bsrf_tb_pkg.sv
sim/tb_top.sv
